@@ src/rgb_fx_pkg.sv @@
// Package for the RGB LED effect generator: request types, mode and register
// codes, the jump color table and the half-degree sine tables.
// No dependencies; every design file imports it.
package rgb_fx_pkg;

  // Input request: current time and the wanted effect.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [2:0]  mode;
  } in_item_t;

  // Result request: channel duties and the update flag.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       update;
  } out_item_t;

  // Effect modes. Codes above MODE_SMOOTH behave like MODE_OFF.
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_JUMP    = 3'd1;
  localparam logic [2:0] MODE_STROBE  = 3'd2;
  localparam logic [2:0] MODE_GRADUAL = 3'd3;
  localparam logic [2:0] MODE_SMOOTH  = 3'd4;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_INTERVAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRADUAL_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_INTERVAL  = 2'd2;
  localparam logic [CFG_DATA_W-1:0] JUMP_INTERVAL_RST    = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] GRADUAL_INTERVAL_RST = 16'd20;
  localparam logic [CFG_DATA_W-1:0] SMOOTH_INTERVAL_RST  = 16'd10;

  // Defaults for the top-level parameters.
  localparam int STROBE_PERIOD_DEF = 250;
  localparam int PHASE_STEPS_DEF   = 360;

  // Jump sequence: red, green, blue, yellow, cyan, magenta, white.
  localparam int JUMP_COLOR_CNT = 7;
  localparam logic [2:0] JUMP_LAST = 3'd6;
  localparam logic [23:0] JUMP_COLORS [JUMP_COLOR_CNT] = '{
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'hFFFFFF
  };

  // Full wave is 720 half-degree steps; a quarter wave has 181 points.
  localparam int WAVE_LEN   = 720;
  localparam int WAVE_IDX_W = 10;
  localparam int QUARTER    = 180;
  localparam int HALF       = 360;
  localparam int THREE_QTR  = 540;
  localparam int GREEN_OFS  = 240;
  localparam int BLUE_OFS   = 480;

  typedef logic [7:0] wave_tab_t [0:QUARTER];

  localparam logic [63:0] Q60_ONE  = 64'd1 << 60;
  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_STEP  = PI_Q60 / 64'd360;
  localparam logic [63:0] LO_MASK  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] DUTY_MID = 64'd255 << 52;

  // Taylor series divisors (2n)(2n+1) for n = 1..15.
  localparam logic [63:0] SERIES_DIV [1:15] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
    64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930
  };

  // (a*b) >> 60 in Q60, built from 32-bit partial products.
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = a & LO_MASK;
    ah  = a >> 32;
    bl  = b & LO_MASK;
    bh  = b >> 32;
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + (lh & LO_MASK) + (hl & LO_MASK);
    lo  = (ll & LO_MASK) | (mid << 32);
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 4) | (lo >> 60);
  endfunction

  // Sine of j half-degrees in Q60, exact at the ends of the quarter wave.
  function automatic logic [63:0] sine_q60(int j);
    logic [63:0] x, x2, term, sum;
    x   = PI_STEP * 64'(j);
    x2  = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 16; n++) begin
      term = mul_q60(term, x2) / SERIES_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (j == 0) begin
      sum = 64'd0;
    end else if (j >= QUARTER) begin
      sum = Q60_ONE;
    end
    return sum;
  endfunction

  // Duty for a quarter-wave point, upper or lower half of the wave.
  function automatic wave_tab_t build_wave(logic neg);
    wave_tab_t   tab;
    logic [63:0] m, v;
    for (int j = 0; j <= QUARTER; j++) begin
      m = (sine_q60(j) >> 8) * 64'd255;
      v = neg ? (DUTY_MID - m) : (DUTY_MID + m);
      tab[j] = v[60:53];
    end
    return tab;
  endfunction

  localparam wave_tab_t WAVE_POS = build_wave(1'b0);
  localparam wave_tab_t WAVE_NEG = build_wave(1'b1);

endpackage

@@ src/rgb_led_effect_generator_top.sv @@
// Top level of the RGB LED effect generator: input stage, effect logic and
// result register. Depends on rgb_fx_pkg for types, codes and tables.
//
// A request is held in the input stage and is registered into the result
// register once that register is free or being drained by the sink.
// Throughput: one request per cycle; an input stage holds one request while
// a finished result waits, so the input only stalls when both are full and
// the sink does not take the result.
// Reset (synchronous, active high) clears the effect state and both stage
// valids and loads the interval registers with their defaults.
module rgb_led_effect_generator_top
  import rgb_fx_pkg::*;
#(
  parameter int STROBE_PERIOD = STROBE_PERIOD_DEF,
  parameter int PHASE_STEPS   = PHASE_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PHASE_W = (PHASE_STEPS > 2) ? $clog2(PHASE_STEPS) : 1;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_STEPS - 1);

  // Reciprocal for the strobe divide: estimate is the quotient or one less.
  localparam int STROBE_SHIFT = 31 + $clog2(STROBE_PERIOD);
  localparam logic [63:0] STROBE_RECIP_W = (64'd1 << STROBE_SHIFT) / 64'(STROBE_PERIOD);
  localparam logic [31:0] STROBE_RECIP = STROBE_RECIP_W[31:0];
  localparam logic [31:0] STROBE_LEN = 32'(STROBE_PERIOD);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] jump_interval;
  logic [CFG_DATA_W-1:0] gradual_interval;
  logic [CFG_DATA_W-1:0] smooth_interval;

  // Effect state.
  logic [2:0]         active_mode;
  logic [31:0]        last_event_time;
  logic [2:0]         color_index;
  logic [PHASE_W-1:0] phase_step;

  // Input stage.
  logic        pend;
  logic [31:0] pend_now;
  logic [2:0]  pend_mode;
  logic [31:0] pend_quot;

  // Next values from the effect logic.
  logic [31:0]        last_event_time_next;
  logic [2:0]         color_index_next;
  logic [PHASE_W-1:0] phase_step_next;
  out_item_t          result_next;

  logic        advance;
  logic [63:0] quot_prod;

  // Working signals of the effect logic.
  logic               mode_chg;
  logic [31:0]        base_last;
  logic [2:0]         base_color;
  logic [PHASE_W-1:0] base_phase;
  logic [PHASE_W-1:0] phase_inc;
  logic [31:0]        elapsed;
  logic [31:0]        strobe_rem;
  logic               strobe_odd;
  logic [15:0]        wave_interval;
  logic [23:0]        jump_rgb;

  // Map a wave position (below twice the wave length) to a duty value.
  function automatic logic [7:0] wave_at(logic [WAVE_IDX_W:0] sum);
    logic [WAVE_IDX_W:0] k;
    logic [WAVE_IDX_W:0] j;
    logic                neg;
    k   = (sum >= (WAVE_IDX_W+1)'(WAVE_LEN)) ? sum - (WAVE_IDX_W+1)'(WAVE_LEN) : sum;
    neg = 1'b0;
    if (k <= (WAVE_IDX_W+1)'(QUARTER)) begin
      j = k;
    end else if (k <= (WAVE_IDX_W+1)'(HALF)) begin
      j = (WAVE_IDX_W+1)'(HALF) - k;
    end else if (k <= (WAVE_IDX_W+1)'(THREE_QTR)) begin
      j   = k - (WAVE_IDX_W+1)'(HALF);
      neg = 1'b1;
    end else begin
      j   = (WAVE_IDX_W+1)'(WAVE_LEN) - k;
      neg = 1'b1;
    end
    return neg ? WAVE_NEG[j[7:0]] : WAVE_POS[j[7:0]];
  endfunction

  // The input stage moves on when the result register is free or draining.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !pend || advance;

  // First step of the strobe divide, registered with the request.
  assign quot_prod = 64'(in_data.now_ms) * 64'(STROBE_RECIP);

  // Effect logic for the request in the input stage.
  always_comb begin
    mode_chg   = pend_mode != active_mode;
    base_last  = mode_chg ? pend_now : last_event_time;
    base_color = mode_chg ? 3'd0 : color_index;
    base_phase = mode_chg ? '0 : phase_step;
    elapsed    = pend_now - base_last;
    phase_inc  = (base_phase == PHASE_LAST) ? '0 : base_phase + 1'b1;
    strobe_rem = pend_now - pend_quot * STROBE_LEN;
    strobe_odd = pend_quot[0] ^ (strobe_rem >= STROBE_LEN);
    wave_interval = (pend_mode == MODE_GRADUAL) ? gradual_interval : smooth_interval;
    jump_rgb   = JUMP_COLORS[base_color];

    last_event_time_next = base_last;
    color_index_next     = base_color;
    phase_step_next      = base_phase;
    result_next          = '0;

    case (pend_mode)
      MODE_JUMP: begin
        if (elapsed >= 32'(jump_interval)) begin
          last_event_time_next = pend_now;
          color_index_next     = (base_color == JUMP_LAST) ? 3'd0 : base_color + 3'd1;
          result_next.red      = jump_rgb[23:16];
          result_next.green    = jump_rgb[15:8];
          result_next.blue     = jump_rgb[7:0];
          result_next.update   = 1'b1;
        end
      end
      MODE_STROBE: begin
        result_next.red    = strobe_odd ? 8'h00 : 8'hFF;
        result_next.green  = strobe_odd ? 8'h00 : 8'hFF;
        result_next.blue   = strobe_odd ? 8'h00 : 8'hFF;
        result_next.update = 1'b1;
        if (elapsed >= STROBE_LEN) begin
          last_event_time_next = pend_now;
        end
      end
      MODE_GRADUAL, MODE_SMOOTH: begin
        if (elapsed >= 32'(wave_interval)) begin
          last_event_time_next = pend_now;
          phase_step_next      = phase_inc;
          result_next.red      = wave_at((WAVE_IDX_W+1)'(phase_inc));
          result_next.green    = wave_at((WAVE_IDX_W+1)'(phase_inc)
                                         + (WAVE_IDX_W+1)'(GREEN_OFS));
          result_next.blue     = wave_at((WAVE_IDX_W+1)'(phase_inc)
                                         + (WAVE_IDX_W+1)'(BLUE_OFS));
          result_next.update   = 1'b1;
        end
      end
      default: begin
        // Off and unused codes drive black.
        result_next.update = 1'b1;
      end
    endcase
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_interval    <= JUMP_INTERVAL_RST;
      gradual_interval <= GRADUAL_INTERVAL_RST;
      smooth_interval  <= SMOOTH_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_JUMP_INTERVAL:    jump_interval    <= cfg_data;
        REG_GRADUAL_INTERVAL: gradual_interval <= cfg_data;
        REG_SMOOTH_INTERVAL:  smooth_interval  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage and result register, with the effect state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend            <= 1'b0;
      out_valid       <= 1'b0;
      active_mode     <= MODE_OFF;
      last_event_time <= '0;
      color_index     <= '0;
      phase_step      <= '0;
    end else begin
      if (pend && advance) begin
        active_mode     <= pend_mode;
        last_event_time <= last_event_time_next;
        color_index     <= color_index_next;
        phase_step      <= phase_step_next;
        out_data        <= result_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_ready) begin
        pend <= in_valid;
        if (in_valid) begin
          pend_now  <= in_data.now_ms;
          pend_mode <= in_data.mode;
          pend_quot <= 32'(quot_prod >> STROBE_SHIFT);
        end
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for rgb_led_effect_generator_top: an in-bench color
// model predicts every result request, and a checker compares them in order.
// Depends on rgb_fx_pkg for the request types, mode codes and register indexes.
module tb;
  import rgb_fx_pkg::*;

  localparam int STROBE_MS = STROBE_PERIOD_DEF;
  localparam int PHASE_CNT = PHASE_STEPS_DEF;
  localparam int LUT_LEN   = 720;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Copy of the block's registers and effect state.
  logic [15:0] jump_ms    = 16'd1000;
  logic [15:0] gradual_ms = 16'd20;
  logic [15:0] smooth_ms  = 16'd10;
  logic [2:0]  cur_mode   = MODE_OFF;
  logic [31:0] last_evt_ms = '0;
  int unsigned jump_idx   = 0;
  int unsigned phase      = 0;
  logic [7:0]  duty_lut [LUT_LEN];

  // Jump sequence: red, green, blue, yellow, cyan, magenta, white.
  localparam logic [23:0] JUMP_RGB [7] = '{
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'hFFFFFF
  };

  out_item_t   led_expected [$];
  int          fail_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  // Random stimulus state.
  logic [31:0] stim_now  = '0;
  logic [2:0]  stim_mode = MODE_OFF;

  rgb_led_effect_generator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fixed point product (a*b) >> 60 from 32-bit partial products.
  function automatic logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = a & 64'hFFFF_FFFF;
    ah  = a >> 32;
    bl  = b & 64'hFFFF_FFFF;
    bh  = b >> 32;
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + (lh & 64'hFFFF_FFFF) + (hl & 64'hFFFF_FFFF);
    lo  = (ll & 64'hFFFF_FFFF) | (mid << 32);
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 4) | (lo >> 60);
  endfunction

  // Sine of j half-degrees (0..180) in Q60 by a Taylor series.
  function automatic logic [63:0] half_deg_sine(int unsigned j);
    logic [63:0] x, x2, term, sum;
    if (j == 0) return 64'd0;
    if (j >= 180) return 64'd1 << 60;
    x    = (64'h3243F6A8885A308D / 64'd360) * 64'(j);
    x2   = q60_product(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 16 && term != 0; n++) begin
      term = q60_product(term, x2) / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Computes the expected result of one request and advances the state.
  function automatic out_item_t led_color_step(in_item_t req);
    out_item_t   res;
    logic [31:0] elapsed;
    logic [31:0] gap;
    logic        lit;
    res = '0;
    if (req.mode != cur_mode) begin
      cur_mode    = req.mode;
      last_evt_ms = req.now_ms;
      jump_idx    = 0;
      phase       = 0;
    end
    elapsed = req.now_ms - last_evt_ms;
    case (cur_mode)
      MODE_JUMP: begin
        if (elapsed >= {16'd0, jump_ms}) begin
          last_evt_ms = req.now_ms;
          {res.red, res.green, res.blue} = JUMP_RGB[jump_idx];
          jump_idx = (jump_idx + 1) % 7;
          res.update = 1'b1;
        end
      end
      MODE_STROBE: begin
        lit = ((req.now_ms / 32'(STROBE_MS)) & 32'd1) == 32'd0;
        res.red    = lit ? 8'hFF : 8'h00;
        res.green  = res.red;
        res.blue   = res.red;
        res.update = 1'b1;
        if (elapsed >= 32'(STROBE_MS)) last_evt_ms = req.now_ms;
      end
      MODE_GRADUAL, MODE_SMOOTH: begin
        gap = (cur_mode == MODE_GRADUAL) ? {16'd0, gradual_ms} : {16'd0, smooth_ms};
        if (elapsed >= gap) begin
          last_evt_ms = req.now_ms;
          phase      = (phase + 1) % PHASE_CNT;
          res.red    = duty_lut[phase % LUT_LEN];
          res.green  = duty_lut[(phase + 240) % LUT_LEN];
          res.blue   = duty_lut[(phase + 480) % LUT_LEN];
          res.update = 1'b1;
        end
      end
      default: begin
        res.update = 1'b1;
      end
    endcase
    return res;
  endfunction

  // The sink stalls at random according to the current idle phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each accepted result request with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (led_expected.size() == 0) begin
        $error("result with no expectation: %h", out_data);
        fail_count++;
      end else begin
        want = led_expected.pop_front();
        if (out_data.red !== want.red) begin
          $error("red: expected %0d, actual %0d", want.red, out_data.red);
          fail_count++;
        end
        if (out_data.green !== want.green) begin
          $error("green: expected %0d, actual %0d", want.green, out_data.green);
          fail_count++;
        end
        if (out_data.blue !== want.blue) begin
          $error("blue: expected %0d, actual %0d", want.blue, out_data.blue);
          fail_count++;
        end
        if (out_data.update !== want.update) begin
          $error("update: expected %0d, actual %0d", want.update, out_data.update);
          fail_count++;
        end
      end
    end
  end

  // Sends one input request; returns at the edge that accepts it.
  task automatic send_req(in_item_t req);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    led_expected.push_back(led_color_step(req));
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (led_expected.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three interval registers while the block is idle.
  task automatic load_intervals(logic [15:0] jump, logic [15:0] gradual, logic [15:0] smooth);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_JUMP_INTERVAL;
    cfg_data  <= jump;
    @(posedge clk);
    cfg_index <= REG_GRADUAL_INTERVAL;
    cfg_data  <= gradual;
    @(posedge clk);
    cfg_index <= REG_SMOOTH_INTERVAL;
    cfg_data  <= smooth;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    jump_ms    = jump;
    gradual_ms = gradual;
    smooth_ms  = smooth;
  endtask

  // Next random request: mostly runs of one mode with time stepping near the
  // active interval, plus wraps, random jumps in time and mode changes.
  task automatic send_random_req();
    int unsigned span;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      stim_mode = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    end
    case (stim_mode)
      MODE_JUMP:    span = jump_ms;
      MODE_STROBE:  span = STROBE_MS;
      MODE_GRADUAL: span = gradual_ms;
      MODE_SMOOTH:  span = smooth_ms;
      default:      span = 16;
    endcase
    sel = $urandom_range(99);
    if (sel < 55) begin
      stim_now = stim_now + $urandom_range(span + span / 2 + 1);
    end else if (sel < 70) begin
      stim_now = stim_now + $urandom_range(3);
    end else if (sel < 82) begin
      stim_now = stim_now + span;
    end else if (sel < 90) begin
      stim_now = stim_now + span - (span > 0);
    end else if (sel < 95) begin
      stim_now = $urandom();
    end else begin
      stim_now = 32'hFFFF_FFFF - $urandom_range(2 * span + 4);
    end
    send_req('{now_ms: stim_now, mode: stim_mode});
  endtask

  // Every mode at the reset intervals, with thresholds and time wrap.
  task automatic test_directed_modes();
    send_req('{now_ms: 32'd0, mode: MODE_OFF});
    send_req('{now_ms: 32'd5, mode: MODE_JUMP});
    send_req('{now_ms: 32'd1004, mode: MODE_JUMP});
    send_req('{now_ms: 32'd1005, mode: MODE_JUMP});
    send_req('{now_ms: 32'd2005, mode: MODE_JUMP});
    send_req('{now_ms: 32'hFFFF_FFFF, mode: MODE_JUMP});
    send_req('{now_ms: 32'h0000_03E6, mode: MODE_JUMP});
    send_req('{now_ms: 32'h0000_03E7, mode: MODE_JUMP});
    send_req('{now_ms: 32'd249, mode: MODE_STROBE});
    send_req('{now_ms: 32'd250, mode: MODE_STROBE});
    send_req('{now_ms: 32'd500, mode: MODE_STROBE});
    send_req('{now_ms: 32'hFFFF_FFFF, mode: MODE_STROBE});
    send_req('{now_ms: 32'd100, mode: MODE_GRADUAL});
    send_req('{now_ms: 32'd120, mode: MODE_GRADUAL});
    send_req('{now_ms: 32'd139, mode: MODE_GRADUAL});
    send_req('{now_ms: 32'hFFFF_0000, mode: MODE_GRADUAL});
    send_req('{now_ms: 32'd7, mode: MODE_SMOOTH});
    send_req('{now_ms: 32'd17, mode: MODE_SMOOTH});
    send_req('{now_ms: 32'd17, mode: 3'd5});
    send_req('{now_ms: 32'd18, mode: 3'd6});
    send_req('{now_ms: 32'd19, mode: 3'd7});
    send_req('{now_ms: 32'd19, mode: 3'd7});
    send_req('{now_ms: 32'd20, mode: MODE_OFF});
    send_req('{now_ms: 32'hFFFF_FFFF, mode: MODE_OFF});
  endtask

  // Random runs under each idle pattern and several interval settings,
  // including the minimum, the maximum and zero.
  task automatic test_interval_sweep();
    int unsigned sender_pct [4] = '{0, 87, 0, 14};
    int unsigned sink_pct [4]   = '{0, 0, 87, 14};
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 4; s++) begin
        case (s)
          0: load_intervals(16'd1, 16'd1, 16'd1);
          1: load_intervals(16'hFFFF, 16'hFFFF, 16'hFFFF);
          2: load_intervals(16'd0, 16'd0, 16'd0);
          default: load_intervals(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 300)),
                                  16'($urandom_range(1, 100)));
        endcase
        sender_idle_pct = sender_pct[p];
        sink_stall_pct  = sink_pct[p];
        repeat (20) send_random_req();
      end
    end
  endtask

  // A long gradual run so the phase step wraps around its full cycle.
  task automatic test_phase_wrap();
    load_intervals(16'd1000, 16'd1, 16'd3);
    sender_idle_pct = 14;
    sink_stall_pct  = 14;
    stim_now = $urandom();
    for (int i = 0; i < 400; i++) begin
      stim_now = stim_now + (($urandom_range(19) == 0) ? 0 : $urandom_range(1, 3000));
      send_req('{now_ms: stim_now, mode: MODE_GRADUAL});
    end
  endtask

  initial begin
    for (int k = 0; k < LUT_LEN; k++) begin : fill_lut
      logic [63:0] m;
      logic [63:0] v;
      logic        neg;
      neg = (k > 360);
      if (k <= 180) m = half_deg_sine(k);
      else if (k <= 360) m = half_deg_sine(360 - k);
      else if (k <= 540) m = half_deg_sine(k - 360);
      else m = half_deg_sine(720 - k);
      m = (m >> 8) * 64'd255;
      v = neg ? ((64'd255 << 52) - m) : ((64'd255 << 52) + m);
      duty_lut[k] = v[60:53];
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_modes();
    test_interval_sweep();
    test_phase_wrap();
    wait_idle();
    if (fail_count == 0) begin
      $display("[rgb_led_effect_generator_top] OK");
    end else begin
      $display("[rgb_led_effect_generator_top] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("[rgb_led_effect_generator_top] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/rgb_fx_pkg.sv
src/rgb_led_effect_generator_top.sv
tb/sv/tb.sv
